// ===== hdl/bed_pkg.sv =====
// Types, character codes and helpers for the backslash escape decoder.
package bed_pkg;

    localparam int WINDOW_BYTES = 12;

    // Request: one escape window with its position in the text
    typedef struct packed {
        logic [63:0] window_low;
        logic [31:0] window_high;
        logic [3:0]  bytes_available;
        logic [23:0] line_in;
        logic [15:0] col_in;
    } t_req;

    // One decoded byte
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        last;
        logic        status;
        logic [3:0]  consumed;
        logic [23:0] line_out;
        logic [15:0] col_out;
    } t_res;

    // Fields shared by every result of one escape
    typedef struct packed {
        logic        byte_valid;
        logic        status;
        logic [3:0]  consumed;
        logic [23:0] line_out;
        logic [15:0] col_out;
    } t_hdr;

    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_V      = 8'h76;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_1      = 8'h31;
    localparam logic [7:0] CH_2      = 8'h32;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LF     = 8'h0A;

    // {ok, value} for one hex digit, either case
    function automatic logic [4:0] hex_nib(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, 4'(c[3:0] + 4'd9)};
        end
        return r;
    endfunction

endpackage

// ===== hdl/backslash_escape_decoder.sv =====
// Backslash escape decoder: request register, single-pass decode, byte emitter.
//
//  channel   direction  handshake            payload
//  request   in         start / busy         i_req (t_req)
//  result    out        o_valid strobe       o_res (t_res)
//
// A request is registered, decoded in one pass into a 1 to 4 byte buffer, and
// the buffer emits one result per cycle through the output register. The first
// result reaches the ports by way of the request register, the byte buffer and
// the output register, and a new request can be accepted while the bytes of the
// previous escape still go out. busy is high while a registered request waits
// for the emitter to reach its last byte. Synchronous active-low reset empties
// all stages. Results cannot be held off.
module backslash_escape_decoder
    import bed_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_valid,
    output t_res o_res
);

    logic       r_in_vld, n_in_vld;
    t_req       r_req;
    logic [2:0] r_cnt, n_cnt;
    logic [7:0] r_bytes [4];
    t_hdr       r_hdr;
    logic       r_out_vld, n_out_vld;
    t_res       r_out;

    logic       accept, load;

    // decode signals
    logic [7:0]  w [WINDOW_BYTES];
    logic [7:0]  c1;
    logic [4:0]  n2, n3, n4, n5, n8, n9, n10, n11;
    logic        hx_ok, hq_ok, lq_ok, pair, lo_sur, oct_ok;
    logic [15:0] cp, lo;
    logic [20:0] full;
    logic [3:0]  avail;
    logic        d_err, d_nl;
    logic [2:0]  d_nb;
    logic [3:0]  d_used;
    logic [7:0]  d_ob [4];
    t_hdr        d_hdr;

    assign load   = r_in_vld && (r_cnt <= 3'd1);
    assign busy   = r_in_vld && !load;
    assign accept = start && !busy;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            w[i] = r_req.window_low[8*i +: 8];
        end
        for (int i = 0; i < 4; i++) begin
            w[8+i] = r_req.window_high[8*i +: 8];
        end
    end

    assign avail = r_req.bytes_available;
    assign c1    = w[1];
    assign n2    = hex_nib(w[2]);
    assign n3    = hex_nib(w[3]);
    assign n4    = hex_nib(w[4]);
    assign n5    = hex_nib(w[5]);
    assign n8    = hex_nib(w[8]);
    assign n9    = hex_nib(w[9]);
    assign n10   = hex_nib(w[10]);
    assign n11   = hex_nib(w[11]);
    assign hx_ok = n2[4] && n3[4];
    assign hq_ok = hx_ok && n4[4] && n5[4];
    assign lq_ok = n8[4] && n9[4] && n10[4] && n11[4];
    assign cp    = {n2[3:0], n3[3:0], n4[3:0], n5[3:0]};
    assign lo    = {n8[3:0], n9[3:0], n10[3:0], n11[3:0]};
    // high surrogate followed by a second \u that fits in the window
    assign pair  = (cp[15:10] == 6'b110110) && (avail >= 4'(WINDOW_BYTES))
                   && (w[6] == CH_BSLASH) && (w[7] == CH_U);
    assign lo_sur = (lo[15:10] == 6'b110111);
    assign full   = 21'h10000 + {1'b0, cp[9:0], lo[9:0]};
    assign oct_ok = (avail >= 4'd4) && (w[2][7:3] == 5'b00110) && (w[3][7:3] == 5'b00110);

    always_comb begin
        d_err  = 1'b0;
        d_nl   = 1'b0;
        d_nb   = 3'd0;
        d_used = 4'd0;
        for (int i = 0; i < 4; i++) begin
            d_ob[i] = 8'h00;
        end
        if (avail < 4'd2) begin
            d_err = 1'b1;
        end else begin
            unique case (c1)
                CH_A: begin d_ob[0] = 8'h07; d_nb = 3'd1; d_used = 4'd2; end
                CH_B: begin d_ob[0] = 8'h08; d_nb = 3'd1; d_used = 4'd2; end
                CH_E: begin d_ob[0] = 8'h1B; d_nb = 3'd1; d_used = 4'd2; end
                CH_T: begin d_ob[0] = 8'h09; d_nb = 3'd1; d_used = 4'd2; end
                CH_N: begin d_ob[0] = 8'h0A; d_nb = 3'd1; d_used = 4'd2; end
                CH_V: begin d_ob[0] = 8'h0B; d_nb = 3'd1; d_used = 4'd2; end
                CH_F: begin d_ob[0] = 8'h0C; d_nb = 3'd1; d_used = 4'd2; end
                CH_R: begin d_ob[0] = 8'h0D; d_nb = 3'd1; d_used = 4'd2; end
                CH_BSLASH, CH_DQUOTE, CH_SQUOTE, CH_SLASH: begin
                    d_ob[0] = c1; d_nb = 3'd1; d_used = 4'd2;
                end
                CH_0, CH_1, CH_2: begin
                    if (oct_ok) begin
                        d_ob[0] = {c1[1:0], w[2][2:0], w[3][2:0]};
                        d_nb    = 3'd1;
                        d_used  = 4'd4;
                    end else if (c1 == CH_0) begin
                        d_ob[0] = 8'h00; d_nb = 3'd1; d_used = 4'd2;
                    end
                end
                CH_X: begin
                    if (avail >= 4'd4) begin
                        if (!hx_ok) begin
                            d_err = 1'b1;
                        end else begin
                            d_ob[0] = {n2[3:0], n3[3:0]};
                            d_nb    = 3'd1;
                            d_used  = 4'd4;
                        end
                    end
                end
                CH_U: begin
                    if (avail >= 4'd6) begin
                        if (!hq_ok || (pair && !lq_ok)) begin
                            d_err = 1'b1;
                        end else if (pair && lo_sur) begin
                            d_ob[0] = {5'b11110, full[20:18]};
                            d_ob[1] = {2'b10, full[17:12]};
                            d_ob[2] = {2'b10, full[11:6]};
                            d_ob[3] = {2'b10, full[5:0]};
                            d_nb    = 3'd4;
                            d_used  = 4'd12;
                        end else begin
                            d_used = 4'd6;
                            if (cp[15:7] == 9'd0) begin
                                d_ob[0] = {1'b0, cp[6:0]};
                                d_nb    = 3'd1;
                            end else if (cp[15:11] == 5'd0) begin
                                d_ob[0] = {3'b110, cp[10:6]};
                                d_ob[1] = {2'b10, cp[5:0]};
                                d_nb    = 3'd2;
                            end else begin
                                d_ob[0] = {4'b1110, cp[15:12]};
                                d_ob[1] = {2'b10, cp[11:6]};
                                d_ob[2] = {2'b10, cp[5:0]};
                                d_nb    = 3'd3;
                            end
                        end
                    end
                end
                CH_LF: begin
                    d_nl = 1'b1;
                end
                default: begin
                end
            endcase
            // anything not decoded above passes through raw
            if (!d_err && d_used == 4'd0) begin
                d_ob[0] = w[0];
                d_ob[1] = w[1];
                d_nb    = 3'd2;
                d_used  = 4'd2;
            end
        end

        if (d_err) begin
            d_nb             = 3'd1;
            d_ob[0]          = 8'h00;
            d_hdr.byte_valid = 1'b0;
            d_hdr.status     = 1'b1;
            d_hdr.consumed   = 4'd0;
            d_hdr.line_out   = r_req.line_in;
            d_hdr.col_out    = r_req.col_in;
        end else begin
            d_hdr.byte_valid = 1'b1;
            d_hdr.status     = 1'b0;
            d_hdr.consumed   = d_used;
            d_hdr.line_out   = d_nl ? 24'(r_req.line_in + 24'd1) : r_req.line_in;
            d_hdr.col_out    = d_nl ? 16'd1 : 16'(r_req.col_in + {12'd0, d_used});
        end
    end

    always_comb begin
        n_in_vld  = accept || (r_in_vld && !load);
        n_out_vld = (r_cnt != 3'd0);
        if (load) begin
            n_cnt = d_nb;
        end else if (r_cnt != 3'd0) begin
            n_cnt = r_cnt - 3'd1;
        end else begin
            n_cnt = r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_cnt     <= 3'd0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_cnt     <= n_cnt;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
        if (r_cnt != 3'd0) begin
            r_out.out_byte   <= r_bytes[0];
            r_out.byte_valid <= r_hdr.byte_valid;
            r_out.last       <= (r_cnt == 3'd1);
            r_out.status     <= r_hdr.status;
            r_out.consumed   <= r_hdr.consumed;
            r_out.line_out   <= r_hdr.line_out;
            r_out.col_out    <= r_hdr.col_out;
        end
        if (load) begin
            r_bytes <= d_ob;
            r_hdr   <= d_hdr;
        end else if (r_cnt != 3'd0) begin
            r_bytes[0] <= r_bytes[1];
            r_bytes[1] <= r_bytes[2];
            r_bytes[2] <= r_bytes[3];
            r_bytes[3] <= 8'h00;
        end
    end

    assign o_valid = r_out_vld;
    assign o_res   = r_out;

endmodule
